### design/msg_pkg.sv
// ----------------------------------------------------------------------------
// msg_pkg: shared definitions of the motion setpoint generator
// Mode and register codes, beat layouts and fraction widths.
// ----------------------------------------------------------------------------
package msg_pkg;

   // fine increments are counted in units of 1/FINE_UNIT of an encoder count
   localparam int FINE_SHIFT = 8;
   localparam int FINE_UNIT  = 1 << FINE_SHIFT;
   localparam int SPD_FRAC_W = FINE_SHIFT + 1;  // signed remainder of speed integration
   localparam int RMP_FRAC_W = FINE_SHIFT;      // unsigned remainder of the ramp

   localparam int POS_W   = 32;
   localparam int PWM_W   = 16;
   localparam int MODE_W  = 3;
   localparam int SPEED_W = 31;

   // drive modes
   localparam logic [MODE_W-1:0] MODE_HOMING   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SPEED    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POSITION = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PWM      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ERROR    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd5;

   // configuration registers
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_POSITION   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_POSITION   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_SPEED      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SYNC_INCREMENT = 2'd3;

   localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 31'd65536;
   localparam logic [SPEED_W-1:0] SYNC_INC_RST  = 31'd256;

   // request beat layout
   localparam int REQ_TDATA_W      = 120;
   localparam int REQ_ENC_LSB      = 0;
   localparam int REQ_ENABLE_BIT   = 32;
   localparam int REQ_LIMIT_UP_BIT = 33;
   localparam int REQ_LIMIT_DN_BIT = 34;
   localparam int REQ_HOME_BIT     = 35;
   localparam int REQ_SPEED_LSB    = 36;
   localparam int REQ_TARGET_LSB   = 68;
   localparam int REQ_PWM_LSB      = 100;
   localparam int REQ_INDEX_BIT    = 116;

   // response beat layout
   localparam int RSP_TDATA_W       = 88;
   localparam int RSP_ECHO_LSB      = 0;
   localparam int RSP_REF_LSB       = 32;
   localparam int RSP_STATUS_LSB    = 64;
   localparam int RSP_SWITCH_LSB    = 67;
   localparam int RSP_PWM_LSB       = 70;
   localparam int RSP_INDEX_REQ_BIT = 86;

   // status and switch bit positions
   localparam int STATUS_SYNC  = 0;
   localparam int STATUS_LIMIT = 1;
   localparam int STATUS_ERROR = 2;
   localparam int SWITCH_UP    = 0;
   localparam int SWITCH_DOWN  = 1;
   localparam int SWITCH_HOME  = 2;

   typedef struct packed {
      logic [2:0]              switches;
      logic [2:0]              status;
      logic signed [POS_W-1:0] reference;
   } rsp_state_type;

   function automatic logic is_position_mode(input logic [MODE_W-1:0] mode);
      return (mode == MODE_HOMING) || (mode == MODE_SPEED) || (mode == MODE_POSITION);
   endfunction

endpackage

### design/motion_setpoint_generator_top.sv
// ----------------------------------------------------------------------------
// motion_setpoint_generator_top: per-tick servo setpoint generator
// rsp_tvalid rises when an accepted req beat passes from the input register into the result register.
// Throughput: one beat per cycle while rsp_tready is high; one register stage does a whole tick.
// Reset clears the valid flags and tick state and loads register defaults; last mode reads idle.
// ----------------------------------------------------------------------------
module motion_setpoint_generator_top
   import msg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // encoder_position, enable_pin, limit_up_pin, limit_down_pin, home_pin,
   // speed_command, target_position, pwm_command, index_found, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // drive_mode
   input  logic [MODE_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // position_echo, position_reference, status_bits, switch_bits, pwm_out,
   // index_request, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // pwm_direct
   output logic [0:0]             rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [POS_W-1:0]       csr_data
);

   // configuration registers
   logic signed [POS_W-1:0] min_pos_ff, max_pos_ff;
   logic [SPEED_W-1:0]      max_speed_ff, sync_inc_ff;

   // pipeline control
   logic in_vld_ff, in_vld_in, out_vld_ff, out_vld_in, adv;
   logic [REQ_TDATA_W-1:0] in_data_ff;
   logic [MODE_W-1:0]      in_user_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;

   // tick state
   logic signed [POS_W-1:0]      last_pos_ff, fine_ff, ref_ff;
   logic signed [POS_W-1:0]      fine_in, ref_in;
   logic [MODE_W-1:0]            last_mode_ff;
   logic signed [SPD_FRAC_W-1:0] spd_frac_ff, spd_frac_in;
   logic [RMP_FRAC_W-1:0]        rmp_frac_ff, rmp_frac_in;
   logic home_seen_ff, home_seen_in, limit_ff, limit_in;
   logic sync_ff, sync_in, iw_ff, iw_in;

   // decoded input
   logic [MODE_W-1:0]       mode;
   logic signed [POS_W-1:0] enc, speed_cmd, target, delta;
   logic signed [PWM_W-1:0] pwm_cmd;
   logic enable_pin, lim_up_pin, lim_dn_pin, home_pin, idx_found;

   // per-mode working values
   logic signed [POS_W-1:0] fine_new, fine_home, fine_clamp;
   logic sync_idx, iw_idx, sync_home, iw_home, hs_home;
   logic signed [POS_W:0] speed_ext, max_speed_ext;

   logic signed [POS_W:0]        spd_sum, spd_adj, spd_coarse, spd_rem;
   logic signed [POS_W-1:0]      ref_spd;
   logic signed [POS_W:0]        fine_ext, mag_ext;
   logic [POS_W:0]               rmp_sum;
   logic [POS_W-FINE_SHIFT:0]    rmp_coarse;
   logic signed [POS_W+1:0]      ref_up, ref_dn, target_ext;
   logic signed [POS_W-1:0]      ref_rmp;
   logic [POS_W:0]               clamp_spd, clamp_rmp;
   logic signed [PWM_W-1:0]      pwm_out;
   logic                         limits_off;

   function automatic logic [POS_W:0] clamp_ref(input logic signed [POS_W-1:0] r,
                                                input logic signed [POS_W-1:0] lo,
                                                input logic signed [POS_W-1:0] hi);
      logic [POS_W:0] res;
      res = {1'b0, r};
      if (lo == hi) begin
         res = {1'b0, r};
      end else if (r < lo) begin
         res = {1'b1, lo};
      end else if (r > hi) begin
         res = {1'b1, hi};
      end
      return res;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pos_ff   <= '0;
         max_pos_ff   <= '0;
         max_speed_ff <= MAX_SPEED_RST;
         sync_inc_ff  <= SYNC_INC_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MIN_POSITION:   min_pos_ff   <= csr_data;
            REG_MAX_POSITION:   max_pos_ff   <= csr_data;
            REG_MAX_SPEED:      max_speed_ff <= csr_data[SPEED_W-1:0];
            REG_SYNC_INCREMENT: sync_inc_ff  <= csr_data[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: input register and result register, each refilled as it drains
   assign adv        = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || adv;
   assign in_vld_in  = req_tready ? req_tvalid : in_vld_ff;
   assign out_vld_in = adv ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_data_ff <= req_tdata;
         in_user_ff <= req_tuser;
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // field decode
   assign mode       = in_user_ff;
   assign enc        = in_data_ff[REQ_ENC_LSB +: POS_W];
   assign enable_pin = in_data_ff[REQ_ENABLE_BIT];
   assign lim_up_pin = in_data_ff[REQ_LIMIT_UP_BIT];
   assign lim_dn_pin = in_data_ff[REQ_LIMIT_DN_BIT];
   assign home_pin   = in_data_ff[REQ_HOME_BIT];
   assign speed_cmd  = in_data_ff[REQ_SPEED_LSB +: POS_W];
   assign target     = in_data_ff[REQ_TARGET_LSB +: POS_W];
   assign pwm_cmd    = in_data_ff[REQ_PWM_LSB +: PWM_W];
   assign idx_found  = in_data_ff[REQ_INDEX_BIT];
   assign delta      = enc - last_pos_ff;
   assign limits_off = (min_pos_ff == max_pos_ff);

   // index completion, then the homing search
   always_comb begin
      sync_idx = sync_ff;
      iw_idx   = iw_ff;
      if (idx_found && iw_ff) begin
         sync_idx = 1'b1;
         iw_idx   = 1'b0;
      end
      sync_home = sync_idx;
      iw_home   = iw_idx;
      hs_home   = home_seen_ff;
      fine_home = fine_ff;
      if (last_mode_ff != MODE_HOMING) begin
         sync_home = 1'b0;
         hs_home   = 1'b0;
         fine_home = delta;
      end
      if (sync_home) begin
         fine_home = '0;
      end else if (home_pin) begin
         hs_home   = 1'b1;
         fine_home = $signed({1'b0, sync_inc_ff});
      end else if (hs_home) begin
         iw_home = 1'b1;
      end else begin
         fine_home = -$signed({1'b0, sync_inc_ff});
      end
   end

   // speed clamp
   assign speed_ext     = {speed_cmd[POS_W-1], speed_cmd};
   assign max_speed_ext = $signed({2'b00, max_speed_ff});
   always_comb begin
      fine_clamp = speed_cmd;
      if (speed_ext > max_speed_ext) begin
         fine_clamp = max_speed_ext[POS_W-1:0];
      end else if (speed_ext < -max_speed_ext) begin
         fine_clamp = -max_speed_ext[POS_W-1:0];
      end
   end

   always_comb begin
      case (mode)
         MODE_HOMING: fine_new = fine_home;
         MODE_SPEED:  fine_new = fine_clamp;
         default:     fine_new = speed_cmd;
      endcase
   end

   // speed integration, quotient truncated toward zero
   assign spd_sum    = {fine_new[POS_W-1], fine_new} +
                       {{(POS_W+1-SPD_FRAC_W){spd_frac_ff[SPD_FRAC_W-1]}}, spd_frac_ff};
   assign spd_adj    = spd_sum + (spd_sum[POS_W] ? $signed((POS_W+1)'(FINE_UNIT - 1))
                                                 : $signed((POS_W+1)'(0)));
   assign spd_coarse = spd_adj >>> FINE_SHIFT;
   assign spd_rem    = spd_sum - (spd_coarse <<< FINE_SHIFT);
   assign ref_spd    = ref_ff + spd_coarse[POS_W-1:0];

   // ramp toward the target
   assign fine_ext   = {fine_new[POS_W-1], fine_new};
   assign mag_ext    = fine_new[POS_W-1] ? -fine_ext : fine_ext;
   assign rmp_sum    = mag_ext + {{(POS_W+1-RMP_FRAC_W){1'b0}}, rmp_frac_ff};
   assign rmp_coarse = rmp_sum[POS_W:FINE_SHIFT];
   assign ref_up     = {{2{ref_ff[POS_W-1]}}, ref_ff} + {{(FINE_SHIFT+1){1'b0}}, rmp_coarse};
   assign ref_dn     = {{2{ref_ff[POS_W-1]}}, ref_ff} - {{(FINE_SHIFT+1){1'b0}}, rmp_coarse};
   assign target_ext = {{2{target[POS_W-1]}}, target};
   always_comb begin
      if (target_ext > ref_up) begin
         ref_rmp = ref_up[POS_W-1:0];
      end else if (target_ext < ref_dn) begin
         ref_rmp = ref_dn[POS_W-1:0];
      end else begin
         ref_rmp = target;
      end
   end

   assign clamp_spd = clamp_ref(ref_spd, min_pos_ff, max_pos_ff);
   assign clamp_rmp = clamp_ref(ref_rmp, min_pos_ff, max_pos_ff);

   // next state and result
   always_comb begin
      fine_in      = fine_ff;
      ref_in       = ref_ff;
      spd_frac_in  = spd_frac_ff;
      rmp_frac_in  = rmp_frac_ff;
      home_seen_in = home_seen_ff;
      limit_in     = limit_ff;
      sync_in      = sync_idx;
      iw_in        = iw_idx;
      pwm_out      = '0;
      case (mode)
         MODE_HOMING: begin
            fine_in      = fine_new;
            sync_in      = sync_home;
            iw_in        = iw_home;
            home_seen_in = hs_home;
            spd_frac_in  = spd_rem[SPD_FRAC_W-1:0];
            ref_in       = ref_spd;
         end
         MODE_SPEED: begin
            fine_in     = fine_new;
            spd_frac_in = spd_rem[SPD_FRAC_W-1:0];
            ref_in      = clamp_spd[POS_W-1:0];
            limit_in    = clamp_spd[POS_W];
         end
         MODE_POSITION: begin
            fine_in     = fine_new;
            rmp_frac_in = rmp_sum[RMP_FRAC_W-1:0];
            ref_in      = clamp_rmp[POS_W-1:0];
            limit_in    = clamp_rmp[POS_W];
         end
         MODE_PWM: begin
            pwm_out  = pwm_cmd;
            limit_in = 1'b0;
            if (!limits_off && (enc < min_pos_ff)) begin
               limit_in = 1'b1;
               if (pwm_cmd[PWM_W-1]) begin
                  pwm_out = '0;
               end
            end else if (!limits_off && (enc > max_pos_ff)) begin
               limit_in = 1'b1;
               if (!pwm_cmd[PWM_W-1]) begin
                  pwm_out = '0;
               end
            end
         end
         default: ;
      endcase
      // coming from a mode without a reference: restart from the encoder
      if (is_position_mode(mode) && !is_position_mode(last_mode_ff)) begin
         ref_in = enc;
      end
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_ECHO_LSB +: POS_W]                = enc;
      rsp_data_in[RSP_REF_LSB +: POS_W]                 = ref_in;
      rsp_data_in[RSP_STATUS_LSB + STATUS_SYNC]         = sync_in;
      rsp_data_in[RSP_STATUS_LSB + STATUS_LIMIT]        = limit_in;
      rsp_data_in[RSP_STATUS_LSB + STATUS_ERROR]        = enable_pin || (mode == MODE_ERROR);
      rsp_data_in[RSP_SWITCH_LSB + SWITCH_UP]           = !lim_up_pin;
      rsp_data_in[RSP_SWITCH_LSB + SWITCH_DOWN]         = !lim_dn_pin;
      rsp_data_in[RSP_SWITCH_LSB + SWITCH_HOME]         = !home_pin;
      rsp_data_in[RSP_PWM_LSB +: PWM_W]                 = pwm_out;
      rsp_data_in[RSP_INDEX_REQ_BIT]                    = iw_in;
      rsp_user_in = !is_position_mode(mode);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff  <= '0;
         last_mode_ff <= MODE_IDLE;
         fine_ff      <= '0;
         ref_ff       <= '0;
         spd_frac_ff  <= '0;
         rmp_frac_ff  <= '0;
         home_seen_ff <= 1'b0;
         limit_ff     <= 1'b0;
         sync_ff      <= 1'b0;
         iw_ff        <= 1'b0;
      end else if (adv) begin
         last_pos_ff  <= enc;
         last_mode_ff <= mode;
         fine_ff      <= fine_in;
         ref_ff       <= ref_in;
         spd_frac_ff  <= spd_frac_in;
         rmp_frac_ff  <= rmp_frac_in;
         home_seen_ff <= home_seen_in;
         limit_ff     <= limit_in;
         sync_ff      <= sync_in;
         iw_ff        <= iw_in;
      end
   end

endmodule

### design/msg_checker.sv
// ----------------------------------------------------------------------------
// msg_checker: port checks of the motion setpoint generator
// Watches the response channel and flags results that cannot occur.
// ----------------------------------------------------------------------------
module msg_checker
   import msg_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [0:0]             rsp_tuser
);

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

   // reference-driven beats carry no pwm
   a_pwm_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[RSP_PWM_LSB +: PWM_W] == '0)
      else $error("pwm_out nonzero while reference drives the motor");

   // waiting for the index and being synchronized exclude each other
   a_sync_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[RSP_INDEX_REQ_BIT] &&
                       rsp_tdata[RSP_STATUS_LSB + STATUS_SYNC]))
      else $error("index request while already synchronized");

endmodule

bind motion_setpoint_generator_top msg_checker u_msg_checker (.*);
